>>> rtl/mcfp_pkg.sv
package mcfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int DUTY_W     = 16;
    localparam int PROD_W     = 32;
    localparam int PART_W     = BYTE_W + DUTY_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hFF;
    localparam logic [DUTY_W-1:0] PWM_PERIOD_RESET   = 16'd2000;
    localparam logic [PART_W-1:0] PERIOD_X255_RESET  = 24'd510000;

    localparam logic [DUTY_W:0] FULL_SCALE   = 17'd65535;
    localparam logic [DUTY_W:0] FULL_SCALE_2 = 17'd131070;

    localparam int FORCE_HIGH_BIT = 0;
    localparam int FORCE_LOW_BIT  = 1;

    typedef struct packed {
        logic force_high;
        logic force_low;
    } esc_t;

endpackage

>>> rtl/mcfp_rx_if.sv
interface mcfp_rx_if;
    import mcfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/mcfp_res_if.sv
interface mcfp_res_if;
    import mcfp_pkg::*;

    logic              valid;
    logic              ready;
    logic              direction_update;
    logic              direction_ccw;
    logic              duty_update;
    logic [DUTY_W-1:0] duty_count;

    modport source (output valid, output direction_update, output direction_ccw,
                    output duty_update, output duty_count, input ready);
    modport sink   (input valid, input direction_update, input direction_ccw,
                    input duty_update, input duty_count, output ready);
endinterface

>>> rtl/mcfp_cfg_if.sv
interface mcfp_cfg_if;
    import mcfp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/motor_command_frame_parser.sv
// Each input transfer's result is registered and held until the output takes it.
// Throughput: one byte per cycle; the single output register sets it,
// and input stalls only while that register holds an untaken result.
// Reset (rst_n low, asynchronous): parser hunts for a start byte, direction
// and duty clear to 0, registers return to their reset values.
module motor_command_frame_parser (
    input  logic       clk,
    input  logic       rst_n,
    mcfp_rx_if.sink    rx,
    mcfp_res_if.source res,
    mcfp_cfg_if.sink   cfg
);
    import mcfp_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_HIGH = 3'd2;
    localparam logic [2:0] PH_LOW  = 3'd3;
    localparam logic [2:0] PH_ESC  = 3'd4;

    logic [BYTE_W-1:0] marker_reg;
    logic [DUTY_W-1:0] period_reg;
    logic [PART_W-1:0] p255_reg;

    logic [2:0]        phase_reg, phase_next;
    logic              dir_reg, dir_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [BYTE_W-1:0] data_hi_reg, data_hi_next;
    logic [BYTE_W-1:0] data_lo_reg, data_lo_next;
    logic              dir_upd_reg, dir_upd_next;
    logic              duty_upd_reg, duty_upd_next;
    logic              valid_reg;

    logic              accept;
    logic [PART_W-1:0] hi_part;
    logic [PART_W-1:0] lo_part;
    logic [DUTY_W-1:0] scaled_duty;
    esc_t              esc;

    assign rx.ready  = !valid_reg || res.ready;
    assign accept    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // scaled with the period in force when the frame completes
    assign hi_part        = PART_W'(data_hi_reg) * PART_W'(period_reg);
    assign lo_part        = PART_W'(data_lo_reg) * PART_W'(period_reg);
    assign esc.force_high = rx.rx_byte[FORCE_HIGH_BIT];
    assign esc.force_low  = rx.rx_byte[FORCE_LOW_BIT];

    mcfp_duty_scale u_scale (
        .hi_part     (hi_part),
        .lo_part     (lo_part),
        .period_x255 (p255_reg),
        .esc         (esc),
        .duty        (scaled_duty)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        duty_next     = duty_reg;
        data_hi_next  = data_hi_reg;
        data_lo_next  = data_lo_reg;
        dir_upd_next  = 1'b0;
        duty_upd_next = 1'b0;
        case (phase_reg)
            PH_CMD:
            begin
                dir_next     = (rx.rx_byte == '0);
                dir_upd_next = 1'b1;
                phase_next   = PH_HIGH;
            end
            PH_HIGH:
            begin
                data_hi_next = rx.rx_byte;
                phase_next   = PH_LOW;
            end
            PH_LOW:
            begin
                data_lo_next = rx.rx_byte;
                phase_next   = PH_ESC;
            end
            PH_ESC:
            begin
                if (esc.force_high)
                begin
                    data_hi_next = '1;
                end
                if (esc.force_low)
                begin
                    data_lo_next = '0;
                end
                duty_next     = scaled_duty;
                duty_upd_next = 1'b1;
                phase_next    = PH_HUNT;
            end
            default:
            begin
                phase_next = (rx.rx_byte == marker_reg) ? PH_CMD : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= START_MARKER_RESET;
            period_reg <= PWM_PERIOD_RESET;
            p255_reg   <= PERIOD_X255_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_MARKER:
                begin
                    marker_reg <= cfg.data[BYTE_W-1:0];
                end
                CFG_PWM_PERIOD:
                begin
                    period_reg <= cfg.data;
                    p255_reg   <= {cfg.data, 8'h00} - PART_W'(cfg.data);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            dir_reg      <= 1'b0;
            duty_reg     <= '0;
            data_hi_reg  <= '0;
            data_lo_reg  <= '0;
            dir_upd_reg  <= 1'b0;
            duty_upd_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                dir_reg      <= dir_next;
                duty_reg     <= duty_next;
                data_hi_reg  <= data_hi_next;
                data_lo_reg  <= data_lo_next;
                dir_upd_reg  <= dir_upd_next;
                duty_upd_reg <= duty_upd_next;
                valid_reg    <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid            = valid_reg;
    assign res.direction_update = dir_upd_reg;
    assign res.direction_ccw    = dir_reg;
    assign res.duty_update      = duty_upd_reg;
    assign res.duty_count       = duty_reg;

    a_cmd_sets_dir: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_CMD |=> valid_reg && dir_upd_reg && !duty_upd_reg
            && phase_reg == PH_HIGH)
        else $error("command byte did not update direction");

    a_esc_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_ESC |=> duty_upd_reg && phase_reg == PH_HUNT)
        else $error("escape byte did not complete the frame");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(dir_reg) && $stable(duty_reg))
        else $error("parser state moved without an input transfer");

    a_hunt_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_HUNT |=> !dir_upd_reg && !duty_upd_reg)
        else $error("update flagged while hunting");
endmodule

>>> rtl/mcfp_duty_scale.sv
module mcfp_duty_scale (
    input  logic [mcfp_pkg::PART_W-1:0] hi_part,
    input  logic [mcfp_pkg::PART_W-1:0] lo_part,
    input  logic [mcfp_pkg::PART_W-1:0] period_x255,
    input  mcfp_pkg::esc_t              esc,
    output logic [mcfp_pkg::DUTY_W-1:0] duty
);
    import mcfp_pkg::*;

    logic [PART_W-1:0] hi_sel;
    logic [PART_W-1:0] lo_sel;
    logic [PROD_W-1:0] prod;
    logic [DUTY_W:0]   fold;
    logic [1:0]        corr;
    logic [DUTY_W:0]   quot;

    assign hi_sel = esc.force_high ? period_x255 : hi_part;
    assign lo_sel = esc.force_low ? '0 : lo_part;
    assign prod   = {hi_sel, 8'h00} + PROD_W'(lo_sel);

    // x / 65535 = a + (a + b) / 65535 for x = a * 65536 + b
    assign fold = {1'b0, prod[PROD_W-1:DUTY_W]} + {1'b0, prod[DUTY_W-1:0]};

    always_comb
    begin
        if (fold >= FULL_SCALE_2)
        begin
            corr = 2'd2;
        end
        else if (fold >= FULL_SCALE)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
    end

    assign quot = {1'b0, prod[PROD_W-1:DUTY_W]} + (DUTY_W+1)'(corr);
    assign duty = quot[DUTY_W-1:0];
endmodule
